@@ rtl/rhh_pkg.sv @@
// Shared types and constants for the hexcone RGB-to-HSV pipeline.
// No dependencies; every module of the block imports this package.
package rhh_pkg;

   localparam int CH_W       = 8;   // one color channel
   localparam int HUE_W      = 15;  // hue in 1/64 degree
   localparam int HUE_NUM_W  = 20;  // 3840 * 255 needs 20 bits
   localparam int SAT_NUM_W  = 16;  // 255 * 255 needs 16 bits
   localparam int HUE_QUO_W  = 12;  // hue offset reaches 3840
   localparam int SAT_QUO_W  = 8;   // saturation reaches 255
   localparam int DIV_STAGES = HUE_QUO_W;

   localparam logic [HUE_QUO_W-1:0] HUE_SECTOR     = 12'd3840;
   localparam logic [CH_W-1:0]      SAT_SCALE      = 8'd255;
   localparam logic [HUE_W-1:0]     HUE_GREEN_BASE = 15'd7680;
   localparam logic [HUE_W-1:0]     HUE_BLUE_BASE  = 15'd15360;
   localparam logic [HUE_W-1:0]     HUE_FULL       = 15'd23040;
   localparam logic [HUE_W-1:0]     HUE_MAX        = 15'd23039;

   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   // After max/min search
   typedef struct packed {
      logic              valid;
      logic              zero;      // black or grey pixel
      sector_type        sector;
      logic              neg;       // channel difference below zero
      logic [CH_W-1:0]   diff_mag;
      logic [CH_W-1:0]   delta;
      logic [CH_W-1:0]   value;
   } front_type;

   // Traveling through the divider stages
   typedef struct packed {
      logic                  valid;
      logic                  zero;
      sector_type            sector;
      logic                  neg;
      logic [HUE_NUM_W-1:0]  hue_rem;
      logic [CH_W-1:0]       hue_den;
      logic [HUE_QUO_W-1:0]  hue_quo;
      logic [SAT_NUM_W-1:0]  sat_rem;
      logic [SAT_QUO_W-1:0]  sat_quo;
      logic [CH_W-1:0]       value;   // also the saturation divisor
   } div_type;

endpackage

@@ rtl/rhh_front.sv @@
// Front end: max/min search and sector pick, then numerator scaling.
// Depends on rhh_pkg. Two register stages.
module rhh_front
   import rhh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [CH_W-1:0] red,
   input  logic [CH_W-1:0] green,
   input  logic [CH_W-1:0] blue,
   output div_type         div_out
);

   front_type f1_in, f1_ff;
   div_type   f2_in, f2_ff;

   logic [CH_W-1:0] mx, mn;
   logic [CH_W:0]   diff;   // signed, one bit wider

   always_comb begin
      f1_in = '0;
      f1_in.valid = in_valid;
      if (red >= green && red >= blue) begin
         f1_in.sector = SEC_RED;
         mx   = red;
         diff = {1'b0, green} - {1'b0, blue};
      end else if (green >= blue) begin
         f1_in.sector = SEC_GREEN;
         mx   = green;
         diff = {1'b0, blue} - {1'b0, red};
      end else begin
         f1_in.sector = SEC_BLUE;
         mx   = blue;
         diff = {1'b0, red} - {1'b0, green};
      end
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      f1_in.value    = mx;
      f1_in.delta    = mx - mn;
      f1_in.zero     = (mx == mn);
      f1_in.neg      = diff[CH_W];
      f1_in.diff_mag = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
   end

   // Scale numerators; divider fills in quotient bits later
   always_comb begin
      f2_in = '0;
      f2_in.valid   = f1_ff.valid;
      f2_in.zero    = f1_ff.zero;
      f2_in.sector  = f1_ff.sector;
      f2_in.neg     = f1_ff.neg;
      f2_in.hue_rem = HUE_NUM_W'(f1_ff.diff_mag) * HUE_NUM_W'(HUE_SECTOR);
      f2_in.hue_den = f1_ff.delta;
      f2_in.sat_rem = SAT_NUM_W'(f1_ff.delta) * SAT_NUM_W'(SAT_SCALE);
      f2_in.value   = f1_ff.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff.valid <= 1'b0;
         f2_ff.valid <= 1'b0;
      end else begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
      end
   end

   assign div_out = f2_ff;

endmodule

@@ rtl/rhh_divider.sv @@
// Restoring divider pipeline: one hue quotient bit per stage; the later stages also give one saturation bit.
// Depends on rhh_pkg. DIV_STAGES register stages.
module rhh_divider
   import rhh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  div_type div_in,
   output div_type div_out
);

   div_type stg_in [DIV_STAGES];
   div_type stg_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int BIT = HUE_QUO_W - 1 - k;
      div_type src;

      if (k == 0) begin : g_first
         assign src = div_in;
      end else begin : g_next
         assign src = stg_ff[k-1];
      end

      if (BIT < SAT_QUO_W) begin : g_both
         logic [HUE_NUM_W-1:0] hue_trial;
         logic [SAT_NUM_W-1:0] sat_trial;
         always_comb begin
            stg_in[k] = src;
            hue_trial = HUE_NUM_W'(src.hue_den) << BIT;
            sat_trial = SAT_NUM_W'(src.value) << BIT;
            if (src.hue_rem >= hue_trial) begin
               stg_in[k].hue_rem      = src.hue_rem - hue_trial;
               stg_in[k].hue_quo[BIT] = 1'b1;
            end
            if (src.sat_rem >= sat_trial) begin
               stg_in[k].sat_rem      = src.sat_rem - sat_trial;
               stg_in[k].sat_quo[BIT] = 1'b1;
            end
         end
      end else begin : g_hue
         logic [HUE_NUM_W-1:0] hue_trial;
         always_comb begin
            stg_in[k] = src;
            hue_trial = HUE_NUM_W'(src.hue_den) << BIT;
            if (src.hue_rem >= hue_trial) begin
               stg_in[k].hue_rem      = src.hue_rem - hue_trial;
               stg_in[k].hue_quo[BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[k].valid <= 1'b0;
         end else begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign div_out = stg_ff[DIV_STAGES-1];

endmodule

@@ rtl/rhh_back.sv @@
// Back end: turn sector, sign and quotient into hue; apply grey/black override.
// Depends on rhh_pkg. One output register stage.
module rhh_back
   import rhh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  div_type          div_in,
   output logic             out_valid,
   output logic [HUE_W-1:0] hue_fixed,
   output logic [CH_W-1:0]  sat_fixed,
   output logic [CH_W-1:0]  value
);

   logic [HUE_W-1:0] base;
   logic [HUE_W-1:0] mag_ceil;   // ceiling of the offset for negative sides

   logic             valid_in, valid_ff;
   logic [HUE_W-1:0] hue_in, hue_ff;
   logic [CH_W-1:0]  sat_in, sat_ff;
   logic [CH_W-1:0]  val_in, val_ff;

   always_comb begin
      case (div_in.sector)
         SEC_RED:   base = div_in.neg ? HUE_FULL : '0;
         SEC_GREEN: base = HUE_GREEN_BASE;
         SEC_BLUE:  base = HUE_BLUE_BASE;
         default:   base = '0;
      endcase
      mag_ceil = HUE_W'(div_in.hue_quo) + HUE_W'(div_in.hue_rem != '0);

      valid_in = div_in.valid;
      val_in   = div_in.value;
      if (div_in.zero) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = div_in.neg ? base - mag_ceil : base + HUE_W'(div_in.hue_quo);
         if (hue_in > HUE_MAX) hue_in = HUE_MAX;
         sat_in = div_in.sat_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hue_ff <= hue_in;
      sat_ff <= sat_in;
      val_ff <= val_in;
   end

   assign out_valid = valid_ff;
   assign hue_fixed = hue_ff;
   assign sat_fixed = sat_ff;
   assign value     = val_ff;

endmodule

@@ rtl/rgb_to_hsv_hexcone_core.sv @@
// Top level of the hexcone RGB-to-HSV converter.
// Depends on rhh_pkg, rhh_front, rhh_divider and rhh_back.
//
// Usage:
//  - Input channel: drive req_red/req_green/req_blue and raise start; a pixel
//    beat is taken at every rising edge with start high and busy low. busy
//    never rises, so one pixel can enter on every clock.
//  - Result channel: rsp_valid pulses for one cycle with rsp_hue_fixed
//    (1/64 degree), rsp_sat_fixed (0..255) and rsp_value (max channel).
//    Results leave in arrival order; the receiver cannot stall them.
//  - Pipeline: 2 front stages (max/min, numerator scaling), 12 divider stages
//    (one quotient bit each, the hue quotient needs 12 bits), 1 output stage.
//  - Throughput: one pixel per cycle, set by the fully pipelined divider.
//  - Reset: synchronous, clears all stage valid bits; beats in flight drop.
//  - Black and grey pixels give hue and saturation zero.
module rgb_to_hsv_hexcone_core
   import rhh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [CH_W-1:0]  req_red,
   input  logic [CH_W-1:0]  req_green,
   input  logic [CH_W-1:0]  req_blue,
   output logic             rsp_valid,
   output logic [HUE_W-1:0] rsp_hue_fixed,
   output logic [CH_W-1:0]  rsp_sat_fixed,
   output logic [CH_W-1:0]  rsp_value
);

   div_type front_to_div;
   div_type div_to_back;
   logic    accept;

   // Every stage advances on every clock: never hold the input off
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   rhh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .div_out  (front_to_div)
   );

   rhh_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_in  (front_to_div),
      .div_out (div_to_back)
   );

   rhh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .div_in    (div_to_back),
      .out_valid (rsp_valid),
      .hue_fixed (rsp_hue_fixed),
      .sat_fixed (rsp_sat_fixed),
      .value     (rsp_value)
   );

   // Hue stays below a full circle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue_fixed <= HUE_MAX)
      else $error("hue beyond full circle");

   // Black pixel gives zero hue and saturation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value == '0 |-> rsp_hue_fixed == '0 && rsp_sat_fixed == '0)
      else $error("black pixel with nonzero hue or saturation");

   // Zero saturation only for grey, and grey has zero hue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sat_fixed == '0 |-> rsp_hue_fixed == '0)
      else $error("zero saturation with nonzero hue");

   // Divider leaves remainders below their divisors
   assert property (@(posedge clock) disable iff (reset)
      div_to_back.valid && !div_to_back.zero |->
         div_to_back.hue_rem < HUE_NUM_W'(div_to_back.hue_den) &&
         div_to_back.sat_rem < SAT_NUM_W'(div_to_back.value))
      else $error("divider remainder not reduced");

endmodule
